[hw/rtl/llic_pkg.sv]
// ----------------------------------------------------------------------------
// llic_pkg
// shared widths, status codes and pipeline payload types for the
// two-line intersection block
// ----------------------------------------------------------------------------
package llic_pkg;

    localparam int CW    = 32;          // coordinate port width
    localparam int DW    = CW + 1;      // point difference
    localparam int PW    = 2 * DW;      // product of two differences
    localparam int SW    = PW + 1;      // sum of two products
    localparam int MW    = PW;          // magnitude of a sum
    localparam int HW    = MW / 2;      // multiplier slice
    localparam int SQW   = 2 * MW;      // product of two magnitudes
    localparam int NPW   = MW + DW;     // numerator times direction
    localparam int CFGW  = 17;          // cosine limit register
    localparam int LHW   = SQW + 16;    // dot squared in q16
    localparam int RHW   = SQW + CFGW;  // lengths product times limit
    localparam int NUMW  = NPW + 1;     // rounded dividend
    localparam int DVW   = MW + 1;      // doubled divisor
    localparam int QW    = 34;          // quotient bits
    localparam int OVW   = DVW + QW;    // overflow compare width
    localparam int VW    = QW + 2;      // base plus quotient

    localparam logic [CFGW-1:0] COS_RESET = CFGW'(64231);

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_PAR = 2'd1,
        ST_DEG = 2'd2,
        ST_SAT = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic                 negx;
        logic                 negy;
        logic                 hugex;
        logic                 hugey;
        logic                 deg;
        logic                 par;
    } t_side;

    typedef struct packed {
        logic [DVW-1:0] d2;
        logic [DVW-1:0] rx;
        logic [DVW-1:0] ry;
        logic [QW-1:0]  lox;
        logic [QW-1:0]  loy;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
    } t_div;

endpackage

[hw/rtl/llic_front.sv]
// ----------------------------------------------------------------------------
// llic_front
// nine-stage arithmetic front end: directions, products, parallel test
// and dividend/divisor setup for the divider chain
// ----------------------------------------------------------------------------
module llic_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [llic_pkg::CFGW-1:0]    i_cos,
    input  logic                         i_vld,
    output logic                         o_rdy,
    input  logic signed [llic_pkg::CW-1:0] i_ax,
    input  logic signed [llic_pkg::CW-1:0] i_ay,
    input  logic signed [llic_pkg::CW-1:0] i_aex,
    input  logic signed [llic_pkg::CW-1:0] i_aey,
    input  logic signed [llic_pkg::CW-1:0] i_bx,
    input  logic signed [llic_pkg::CW-1:0] i_by,
    input  logic signed [llic_pkg::CW-1:0] i_bex,
    input  logic signed [llic_pkg::CW-1:0] i_bey,
    output logic                         o_vld,
    output llic_pkg::t_side              o_side,
    output llic_pkg::t_div               o_div,
    input  logic                         i_rdy
);
    import llic_pkg::*;

    localparam int NS  = 9;
    localparam int NCH = SQW / HW;

    function automatic logic [MW-1:0] f_mag(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] n;
        n = -v;
        return v[SW-1] ? MW'(n) : MW'(v);
    endfunction

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_rdy = rdy[0];
    assign o_vld = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: directions
    logic signed [DW-1:0] r1_d1x, r1_d1y, r1_d2x, r1_d2y, r1_ex, r1_ey;
    t_side                r1_side;
    // stage 2: products
    logic signed [PW-1:0] r2_dxx, r2_dyy, r2_axx, r2_ayy, r2_bxx, r2_byy;
    logic signed [PW-1:0] r2_cyx, r2_cxy, r2_nye, r2_nxe;
    logic signed [DW-1:0] r2_d2x, r2_d2y;
    t_side                r2_side;
    // stage 3: sums
    logic signed [SW-1:0] r3_dot, r3_len1, r3_len2, r3_den, r3_num;
    logic signed [DW-1:0] r3_d2x, r3_d2y;
    t_side                r3_side;
    // stage 4: magnitudes and signs
    logic [MW-1:0]        r4_dot, r4_len1, r4_len2, r4_den, r4_num;
    logic [DW-1:0]        r4_d2x, r4_d2y;
    t_side                r4_side;
    // stage 5: partial products
    logic [2*HW-1:0]      r5_sqhh, r5_sqhl, r5_sqll;
    logic [2*HW-1:0]      r5_lhh, r5_lhl, r5_llh, r5_lll;
    logic [HW+DW-1:0]     r5_nxh, r5_nxl, r5_nyh, r5_nyl;
    logic [MW-1:0]        r5_den;
    t_side                r5_side;
    // stage 6: full products
    logic [SQW-1:0]       r6_dot2, r6_len;
    logic [NPW-1:0]       r6_nx, r6_ny;
    logic [MW-1:0]        r6_den;
    t_side                r6_side;
    // stage 7: limit partials, dividend, divisor
    logic [LHW-1:0]       r7_lhs;
    logic [HW+CFGW-1:0]   r7_rp [NCH];
    logic [NUMW-1:0]      r7_nx, r7_ny;
    logic [DVW-1:0]       r7_d2;
    t_side                r7_side;
    // stage 8: limit product, overflow test
    logic [LHW-1:0]       r8_lhs;
    logic [RHW-1:0]       r8_rhs;
    logic [NUMW-1:0]      r8_nx, r8_ny;
    logic [DVW-1:0]       r8_d2;
    t_side                r8_side;
    // stage 9
    t_side                r9_side;
    t_div                 r9_div;

    logic signed [SW-1:0] s3_num;
    logic                 s4_nzx, s4_nzy;
    logic [RHW-1:0]       s8_rhs;
    logic [OVW-1:0]       s8_lim;

    assign s3_num = r3_num;
    assign s4_nzx = (r3_num != '0) && (r3_d2x != '0);
    assign s4_nzy = (r3_num != '0) && (r3_d2y != '0);

    always_comb begin
        s8_rhs = '0;
        for (int k = 0; k < NCH; k++) begin
            s8_rhs = s8_rhs + (RHW'(r7_rp[k]) << (k * HW));
        end
    end

    assign s8_lim = OVW'(r7_d2) << QW;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_d1x       <= DW'(i_aex) - DW'(i_ax);
            r1_d1y       <= DW'(i_aey) - DW'(i_ay);
            r1_d2x       <= DW'(i_bex) - DW'(i_bx);
            r1_d2y       <= DW'(i_bey) - DW'(i_by);
            r1_ex        <= DW'(i_ax) - DW'(i_bx);
            r1_ey        <= DW'(i_ay) - DW'(i_by);
            r1_side      <= '0;
            r1_side.bx   <= i_bx;
            r1_side.by   <= i_by;
        end
        if (rdy[1]) begin
            r2_dxx       <= r1_d1x * r1_d2x;
            r2_dyy       <= r1_d1y * r1_d2y;
            r2_axx       <= r1_d1x * r1_d1x;
            r2_ayy       <= r1_d1y * r1_d1y;
            r2_bxx       <= r1_d2x * r1_d2x;
            r2_byy       <= r1_d2y * r1_d2y;
            r2_cyx       <= r1_d1y * r1_d2x;
            r2_cxy       <= r1_d1x * r1_d2y;
            r2_nye       <= r1_d1y * r1_ex;
            r2_nxe       <= r1_d1x * r1_ey;
            r2_d2x       <= r1_d2x;
            r2_d2y       <= r1_d2y;
            r2_side      <= r1_side;
            r2_side.deg  <= (r1_d1x == '0 && r1_d1y == '0) ||
                            (r1_d2x == '0 && r1_d2y == '0);
        end
        if (rdy[2]) begin
            r3_dot       <= SW'(r2_dxx) + SW'(r2_dyy);
            r3_len1      <= SW'(r2_axx) + SW'(r2_ayy);
            r3_len2      <= SW'(r2_bxx) + SW'(r2_byy);
            r3_den       <= SW'(r2_cyx) - SW'(r2_cxy);
            r3_num       <= SW'(r2_nye) - SW'(r2_nxe);
            r3_d2x       <= r2_d2x;
            r3_d2y       <= r2_d2y;
            r3_side      <= r2_side;
        end
        if (rdy[3]) begin
            r4_dot       <= f_mag(r3_dot);
            r4_len1      <= MW'(r3_len1);
            r4_len2      <= MW'(r3_len2);
            r4_den       <= f_mag(r3_den);
            r4_num       <= f_mag(s3_num);
            r4_d2x       <= r3_d2x[DW-1] ? -r3_d2x : r3_d2x;
            r4_d2y       <= r3_d2y[DW-1] ? -r3_d2y : r3_d2y;
            r4_side      <= r3_side;
            r4_side.negx <= s4_nzx && (r3_num[SW-1] ^ r3_d2x[DW-1] ^ r3_den[SW-1]);
            r4_side.negy <= s4_nzy && (r3_num[SW-1] ^ r3_d2y[DW-1] ^ r3_den[SW-1]);
            r4_side.par  <= (r3_den == '0);
        end
        if (rdy[4]) begin
            r5_sqhh      <= r4_dot[MW-1:HW] * r4_dot[MW-1:HW];
            r5_sqhl      <= r4_dot[MW-1:HW] * r4_dot[HW-1:0];
            r5_sqll      <= r4_dot[HW-1:0] * r4_dot[HW-1:0];
            r5_lhh       <= r4_len1[MW-1:HW] * r4_len2[MW-1:HW];
            r5_lhl       <= r4_len1[MW-1:HW] * r4_len2[HW-1:0];
            r5_llh       <= r4_len1[HW-1:0] * r4_len2[MW-1:HW];
            r5_lll       <= r4_len1[HW-1:0] * r4_len2[HW-1:0];
            r5_nxh       <= r4_num[MW-1:HW] * r4_d2x;
            r5_nxl       <= r4_num[HW-1:0] * r4_d2x;
            r5_nyh       <= r4_num[MW-1:HW] * r4_d2y;
            r5_nyl       <= r4_num[HW-1:0] * r4_d2y;
            r5_den       <= r4_den;
            r5_side      <= r4_side;
        end
        if (rdy[5]) begin
            r6_dot2      <= (SQW'(r5_sqhh) << (2 * HW)) + (SQW'(r5_sqhl) << (HW + 1))
                            + SQW'(r5_sqll);
            r6_len       <= (SQW'(r5_lhh) << (2 * HW))
                            + ((SQW'(r5_lhl) + SQW'(r5_llh)) << HW) + SQW'(r5_lll);
            r6_nx        <= (NPW'(r5_nxh) << HW) + NPW'(r5_nxl);
            r6_ny        <= (NPW'(r5_nyh) << HW) + NPW'(r5_nyl);
            r6_den       <= r5_den;
            r6_side      <= r5_side;
        end
        if (rdy[6]) begin
            r7_lhs       <= LHW'(r6_dot2) << (LHW - SQW);
            for (int k = 0; k < NCH; k++) begin
                r7_rp[k] <= r6_len[k*HW +: HW] * i_cos;
            end
            r7_nx        <= (NUMW'(r6_nx) << 1) + NUMW'(r6_den);
            r7_ny        <= (NUMW'(r6_ny) << 1) + NUMW'(r6_den);
            r7_d2        <= DVW'(r6_den) << 1;
            r7_side      <= r6_side;
        end
        if (rdy[7]) begin
            r8_lhs       <= r7_lhs;
            r8_rhs       <= s8_rhs;
            r8_nx        <= r7_nx;
            r8_ny        <= r7_ny;
            r8_d2        <= r7_d2;
            r8_side      <= r7_side;
            r8_side.hugex <= OVW'(r7_nx) >= s8_lim;
            r8_side.hugey <= OVW'(r7_ny) >= s8_lim;
        end
        if (rdy[8]) begin
            r9_side      <= r8_side;
            r9_side.par  <= r8_side.par || (RHW'(r8_lhs) > r8_rhs);
            r9_div.d2    <= r8_d2;
            r9_div.rx    <= DVW'(r8_nx >> QW);
            r9_div.ry    <= DVW'(r8_ny >> QW);
            r9_div.lox   <= r8_nx[QW-1:0];
            r9_div.loy   <= r8_ny[QW-1:0];
            r9_div.qx    <= '0;
            r9_div.qy    <= '0;
        end
    end

    assign o_side = r9_side;
    assign o_div  = r9_div;

endmodule

[hw/rtl/llic_div_cell.sv]
// ----------------------------------------------------------------------------
// llic_div_cell
// one restoring division step for both coordinates, one quotient bit
// per cell, registered toward the next cell
// ----------------------------------------------------------------------------
module llic_div_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  llic_pkg::t_side i_side,
    input  llic_pkg::t_div  i_div,
    output logic            o_vld,
    output llic_pkg::t_side o_side,
    output llic_pkg::t_div  o_div,
    input  logic            i_rdy
);
    import llic_pkg::*;

    localparam int BIT = QW - 1 - STEP;

    logic            r_vld;
    t_side           r_side;
    t_div            r_div;
    t_div            n_div;
    logic [DVW:0]    tx, ty, dd;
    logic            gex, gey;

    assign o_rdy = !r_vld || i_rdy;

    assign dd  = {1'b0, i_div.d2};
    assign tx  = {i_div.rx, i_div.lox[BIT]};
    assign ty  = {i_div.ry, i_div.loy[BIT]};
    assign gex = tx >= dd;
    assign gey = ty >= dd;

    always_comb begin
        n_div         = i_div;
        n_div.rx      = gex ? DVW'(tx - dd) : DVW'(tx);
        n_div.ry      = gey ? DVW'(ty - dd) : DVW'(ty);
        n_div.qx[BIT] = gex;
        n_div.qy[BIT] = gey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_div  = r_div;

endmodule

[hw/rtl/llic_out.sv]
// ----------------------------------------------------------------------------
// llic_out
// adds the rounded step to the base point, clamps to the coordinate range,
// picks the status and holds the result item
// ----------------------------------------------------------------------------
module llic_out #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  llic_pkg::t_side               i_side,
    input  llic_pkg::t_div                i_div,
    output logic                          o_vld,
    output logic signed [llic_pkg::CW-1:0] o_x,
    output logic signed [llic_pkg::CW-1:0] o_y,
    output logic [1:0]                    o_status,
    input  logic                          i_rdy
);
    import llic_pkg::*;

    localparam logic signed [VW-1:0] C_HI = VW'((longint'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [VW-1:0] C_LO = ~C_HI;

    typedef struct packed {
        logic signed [CW-1:0] val;
        logic                 sat;
    } t_coord;

    function automatic t_coord f_coord(input logic signed [CW-1:0] base,
                                       input logic [QW-1:0] q,
                                       input logic neg, input logic huge);
        t_coord               r;
        logic signed [VW-1:0] v;
        v = neg ? VW'(base) - VW'(q) : VW'(base) + VW'(q);
        if (huge) begin
            r.sat = 1'b1;
            r.val = neg ? CW'(C_LO) : CW'(C_HI);
        end else if (v > C_HI) begin
            r.sat = 1'b1;
            r.val = CW'(C_HI);
        end else if (v < C_LO) begin
            r.sat = 1'b1;
            r.val = CW'(C_LO);
        end else begin
            r.sat = 1'b0;
            r.val = CW'(v);
        end
        return r;
    endfunction

    logic                 r_vld;
    logic signed [CW-1:0] r_x, r_y;
    t_status              r_st;
    t_coord               cx, cy;
    logic signed [CW-1:0] n_x, n_y;
    t_status              n_st;

    assign o_rdy = !r_vld || i_rdy;
    assign cx    = f_coord(i_side.bx, i_div.qx, i_side.negx, i_side.hugex);
    assign cy    = f_coord(i_side.by, i_div.qy, i_side.negy, i_side.hugey);

    always_comb begin
        n_x = '0;
        n_y = '0;
        if (i_side.deg) begin
            n_st = ST_DEG;
        end else if (i_side.par) begin
            n_st = ST_PAR;
        end else begin
            n_x  = cx.val;
            n_y  = cy.val;
            n_st = (cx.sat || cy.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_st <= n_st;
        end
    end

    assign o_vld    = r_vld;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_status = r_st;

endmodule

[hw/rtl/line_line_intersection_core.sv]
// ----------------------------------------------------------------------------
// line_line_intersection_core
// crossing point of two lines given by integer point pairs
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries one item: both lines' two points.
// output channel o_valid/i_ready carries one item per input: the crossing
// point, rounded half away from zero and clamped to COORD_BITS, and a
// status (intersect, parallel, degenerate line, saturated).
// i_cfg_wr_en/i_cfg_wr_data write the squared cosine limit (q16) used by
// the parallel test; write it only while no item is in flight.
// an item passes nine arithmetic stages, a chain of 34 division
// cells producing one quotient bit each, and the output register.
// throughput is one item per cycle unless the output stalls; every stage holds one item.
// each stage moves on when the stage after it is empty or moving, so the
// block keeps taking items while a result waits, until the chain fills.
// a stalled result stays unchanged in the output register.
// reset empties every stage and sets the limit to 0.990 squared.
// ----------------------------------------------------------------------------
module line_line_intersection_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [llic_pkg::CFGW-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [llic_pkg::CW-1:0] i_a_start_x,
    input  logic signed [llic_pkg::CW-1:0] i_a_start_y,
    input  logic signed [llic_pkg::CW-1:0] i_a_end_x,
    input  logic signed [llic_pkg::CW-1:0] i_a_end_y,
    input  logic signed [llic_pkg::CW-1:0] i_b_start_x,
    input  logic signed [llic_pkg::CW-1:0] i_b_start_y,
    input  logic signed [llic_pkg::CW-1:0] i_b_end_x,
    input  logic signed [llic_pkg::CW-1:0] i_b_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [llic_pkg::CW-1:0] o_cross_x,
    output logic signed [llic_pkg::CW-1:0] o_cross_y,
    output logic [1:0]                    o_status
);
    import llic_pkg::*;

    logic [CFGW-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= COS_RESET;
        end else if (i_cfg_wr_en) begin
            r_cos <= i_cfg_wr_data;
        end
    end

    logic  vld_c [QW+1];
    logic  rdy_c [QW+1];
    t_side side_c [QW+1];
    t_div  div_c [QW+1];

    llic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cos   (r_cos),
        .i_vld   (i_valid),
        .o_rdy   (o_ready),
        .i_ax    (i_a_start_x),
        .i_ay    (i_a_start_y),
        .i_aex   (i_a_end_x),
        .i_aey   (i_a_end_y),
        .i_bx    (i_b_start_x),
        .i_by    (i_b_start_y),
        .i_bex   (i_b_end_x),
        .i_bey   (i_b_end_y),
        .o_vld   (vld_c[0]),
        .o_side  (side_c[0]),
        .o_div   (div_c[0]),
        .i_rdy   (rdy_c[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        llic_div_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld_c[g]),
            .o_rdy   (rdy_c[g]),
            .i_side  (side_c[g]),
            .i_div   (div_c[g]),
            .o_vld   (vld_c[g+1]),
            .o_side  (side_c[g+1]),
            .o_div   (div_c[g+1]),
            .i_rdy   (rdy_c[g+1])
        );
    end

    llic_out #(.COORD_BITS(COORD_BITS)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (vld_c[QW]),
        .o_rdy    (rdy_c[QW]),
        .i_side   (side_c[QW]),
        .i_div    (div_c[QW]),
        .o_vld    (o_valid),
        .o_x      (o_cross_x),
        .o_y      (o_cross_y),
        .o_status (o_status),
        .i_rdy    (i_ready)
    );

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DEG || o_status == ST_PAR)
        |-> o_cross_x == '0 && o_cross_y == '0)
        else $error("parallel or degenerate item with nonzero point");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !vld_c[QW] |-> rdy_c[QW])
        else $error("empty output stage not ready");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result present right after reset");

endmodule
